FILE: rtl/mmcsbr_pkg.sv
`default_nettype none

package mmcsbr_pkg;

  // Default geometry
  localparam int BLOCK_BYTES_DEF  = 512;
  localparam int WINDOW_BYTES_DEF = 32;

  // Configuration register indexes
  localparam logic [1:0] REG_DUMMY_BYTES = 2'd0;
  localparam logic [1:0] REG_OP_RETRIES  = 2'd1;
  localparam logic [1:0] REG_RESP_POLLS  = 2'd2;

  localparam logic [7:0] DUMMY_BYTES_RST = 8'd10;
  localparam logic [7:0] OP_RETRIES_RST  = 8'd255;
  localparam logic [7:0] RESP_POLLS_RST  = 8'd255;

  // Request opcodes
  localparam logic [1:0] OP_INIT = 2'd0;
  localparam logic [1:0] OP_READ = 2'd1;
  localparam logic [1:0] OP_RX   = 2'd2;

  // SPI bytes
  localparam logic [7:0] CMD0_CODE  = 8'h40;
  localparam logic [7:0] CMD1_CODE  = 8'h41;
  localparam logic [7:0] CMD17_CODE = 8'h51;
  localparam logic [7:0] CMD_CRC    = 8'h95;
  localparam logic [7:0] IDLE_BYTE  = 8'hFF;
  localparam logic [7:0] START_TOKEN = 8'hFE;
  localparam logic [7:0] R1_IDLE    = 8'h01;

  // Error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_IDLE_RESP = 3'd1;
  localparam logic [2:0] ERR_INIT_TMO  = 3'd2;
  localparam logic [2:0] ERR_READ_RESP = 3'd3;
  localparam logic [2:0] ERR_TOKEN     = 3'd4;
  localparam logic [2:0] ERR_OFFSET    = 3'd5;

endpackage

`default_nettype wire

FILE: rtl/mmc_spi_block_reader.sv
`default_nettype none

// MMC/SD host in SPI mode, byte-driven. Each request (opcode 0 init, 1 read,
// 2 received byte) yields exactly one response naming the next SPI transfer
// (tx_valid, tx_byte, select_active) plus any captured window byte and the
// completion status. Each request passes through a single response
// register, so a new request can be accepted every cycle while the response
// stage is empty or being drained; no reset sweep is needed. Init sends
// dummy bytes with select off, CMD0 (expects 0x01) and then retries CMD1
// until the card answers 0 or the retry limit runs out. A read issues CMD17
// for the block-aligned address, waits (without limit) for the 0xFE token,
// and delivers WINDOW_BYTES bytes starting at the address offset; an offset
// whose window would cross the block end fails at once with error 5.
module mmc_spi_block_reader
  import mmcsbr_pkg::*;
#(
  parameter int BLOCK_BYTES  = BLOCK_BYTES_DEF,
  parameter int WINDOW_BYTES = WINDOW_BYTES_DEF,
  localparam int IDX_W = (WINDOW_BYTES > 1) ? $clog2(WINDOW_BYTES) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  // configuration
  input  wire logic             cfg_write,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [7:0]       cfg_data,
  // request channel
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [1:0]       opcode,
  input  wire logic [31:0]      address,
  input  wire logic [7:0]       rx_byte,
  // response channel
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  tx_valid,
  output logic [7:0]            tx_byte,
  output logic                  select_active,
  output logic                  data_valid,
  output logic [7:0]            data_byte,
  output logic [IDX_W-1:0]      data_index,
  output logic                  done_res,
  output logic [2:0]            error_code
);

  localparam int OFF_W  = $clog2(BLOCK_BYTES);
  localparam int CNT_B  = $clog2(BLOCK_BYTES + 2);
  localparam int CNT_W  = (CNT_B > 8) ? CNT_B : 8;
  localparam int SUM_W  = $clog2(BLOCK_BYTES + WINDOW_BYTES) + 1;
  localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(BLOCK_BYTES + 1);

  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_DUMMY  = 4'd1;
  localparam logic [3:0] PH_CMD0   = 4'd2;
  localparam logic [3:0] PH_RESP0  = 4'd3;
  localparam logic [3:0] PH_OPSEP  = 4'd4;
  localparam logic [3:0] PH_CMD1   = 4'd5;
  localparam logic [3:0] PH_RESP1  = 4'd6;
  localparam logic [3:0] PH_PRE    = 4'd7;
  localparam logic [3:0] PH_CMD17  = 4'd8;
  localparam logic [3:0] PH_RESP17 = 4'd9;
  localparam logic [3:0] PH_TOKEN  = 4'd10;
  localparam logic [3:0] PH_DATA   = 4'd11;

  typedef struct packed {
    logic             tx_valid;
    logic [7:0]       tx_byte;
    logic             select_active;
    logic             data_valid;
    logic [7:0]       data_byte;
    logic [IDX_W-1:0] data_index;
    logic             done_res;
    logic [2:0]       error_code;
  } res_t;

  // configuration
  logic [7:0] dummy_bytes, op_retries, resp_polls;

  // control state
  logic [3:0]       phase, phase_next;
  logic [CNT_W-1:0] byte_counter, byte_counter_next;
  logic [7:0]       poll_counter, poll_counter_next;
  logic [7:0]       retry_counter, retry_counter_next;
  logic [31:0]      block_address, block_address_next;
  logic [OFF_W-1:0] window_offset, window_offset_next;

  res_t res, res_next;
  logic accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dummy_bytes <= DUMMY_BYTES_RST;
      op_retries  <= OP_RETRIES_RST;
      resp_polls  <= RESP_POLLS_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DUMMY_BYTES: dummy_bytes <= cfg_data;
        REG_OP_RETRIES:  op_retries  <= cfg_data;
        REG_RESP_POLLS:  resp_polls  <= cfg_data;
        default: ;
      endcase
    end
  end

  // next frame byte of a command, k = position in the 6-byte frame
  function automatic logic [7:0] frame_byte(input logic [3:0] ph, input logic [2:0] k,
                                            input logic [31:0] baddr);
    logic [7:0] b;
    b = 8'h00;
    if (k == 3'd5) begin
      b = CMD_CRC;
    end else if (ph == PH_CMD17) begin
      unique case (k)
        3'd0:    b = CMD17_CODE;
        3'd1:    b = baddr[31:24];
        3'd2:    b = baddr[23:16];
        3'd3:    b = baddr[15:8];
        3'd4:    b = baddr[7:0];
        default: b = 8'h00;
      endcase
    end else if (k == 3'd0) begin
      b = (ph == PH_CMD0) ? CMD0_CODE : CMD1_CODE;
    end
    return b;
  endfunction

  always_comb begin
    logic [7:0]       limit;
    logic [OFF_W-1:0] off;
    logic [SUM_W-1:0] win_sum;
    logic [CNT_W-1:0] win_lo, win_hi;
    logic [7:0]       retry_inc;
    logic             inwin;

    phase_next         = phase;
    byte_counter_next  = byte_counter;
    poll_counter_next  = poll_counter;
    retry_counter_next = retry_counter;
    block_address_next = block_address;
    window_offset_next = window_offset;
    res_next           = '0;

    limit     = (resp_polls == 8'd0) ? 8'd1 : resp_polls;
    off       = address[OFF_W-1:0];
    win_sum   = SUM_W'(off) + SUM_W'(WINDOW_BYTES);
    win_lo    = CNT_W'(window_offset);
    win_hi    = CNT_W'(window_offset) + CNT_W'(WINDOW_BYTES);
    retry_inc = retry_counter + 8'd1;
    inwin     = (byte_counter >= win_lo) && (byte_counter < win_hi);

    priority if (opcode == OP_INIT) begin
      retry_counter_next = '0;
      poll_counter_next  = '0;
      if (dummy_bytes == 8'd0) begin
        phase_next        = PH_CMD0;
        byte_counter_next = '0;
        res_next.tx_valid = 1'b1;
        res_next.tx_byte  = CMD0_CODE;
        res_next.select_active = 1'b1;
      end else begin
        phase_next        = PH_DUMMY;
        byte_counter_next = CNT_W'(1);
        res_next.tx_valid = 1'b1;
        res_next.tx_byte  = IDLE_BYTE;
      end
    end else if (opcode == OP_READ) begin
      if (win_sum > SUM_W'(BLOCK_BYTES)) begin
        phase_next          = PH_IDLE;
        res_next.done_res   = 1'b1;
        res_next.error_code = ERR_OFFSET;
      end else begin
        window_offset_next = off;
        block_address_next = {address[31:OFF_W], {OFF_W{1'b0}}};
        poll_counter_next  = '0;
        phase_next         = PH_PRE;
        byte_counter_next  = '0;
        res_next.tx_valid  = 1'b1;
        res_next.tx_byte   = IDLE_BYTE;
      end
    end else if (opcode == OP_RX && phase != PH_IDLE) begin
      unique case (phase)
        PH_DUMMY: begin
          res_next.tx_valid = 1'b1;
          if (byte_counter < CNT_W'(dummy_bytes)) begin
            byte_counter_next = byte_counter + CNT_W'(1);
            res_next.tx_byte  = IDLE_BYTE;
          end else begin
            phase_next        = PH_CMD0;
            byte_counter_next = '0;
            res_next.tx_byte  = CMD0_CODE;
            res_next.select_active = 1'b1;
          end
        end
        PH_CMD0, PH_CMD1, PH_CMD17: begin
          res_next.tx_valid      = 1'b1;
          res_next.select_active = 1'b1;
          if (byte_counter < CNT_W'(5)) begin
            byte_counter_next = byte_counter + CNT_W'(1);
            res_next.tx_byte  = frame_byte(phase, byte_counter[2:0] + 3'd1, block_address);
          end else begin
            phase_next        = phase + 4'd1;
            poll_counter_next = 8'd1;
            res_next.tx_byte  = IDLE_BYTE;
          end
        end
        PH_RESP0, PH_RESP1, PH_RESP17: begin
          if (rx_byte != IDLE_BYTE || poll_counter >= limit) begin
            // response byte decides
            if (phase == PH_RESP0) begin
              if (rx_byte != R1_IDLE) begin
                phase_next          = PH_IDLE;
                res_next.done_res   = 1'b1;
                res_next.error_code = ERR_IDLE_RESP;
              end else begin
                retry_counter_next = '0;
                if (op_retries == 8'd0) begin
                  phase_next          = PH_IDLE;
                  res_next.done_res   = 1'b1;
                  res_next.error_code = ERR_INIT_TMO;
                end else begin
                  phase_next        = PH_OPSEP;
                  res_next.tx_valid = 1'b1;
                  res_next.tx_byte  = IDLE_BYTE;
                end
              end
            end else if (phase == PH_RESP1) begin
              if (rx_byte == 8'h00) begin
                phase_next        = PH_IDLE;
                res_next.done_res = 1'b1;
              end else begin
                retry_counter_next = retry_inc;
                if (retry_inc >= op_retries) begin
                  phase_next          = PH_IDLE;
                  res_next.done_res   = 1'b1;
                  res_next.error_code = ERR_INIT_TMO;
                end else begin
                  phase_next        = PH_OPSEP;
                  res_next.tx_valid = 1'b1;
                  res_next.tx_byte  = IDLE_BYTE;
                end
              end
            end else begin
              if (rx_byte != 8'h00) begin
                phase_next          = PH_IDLE;
                res_next.done_res   = 1'b1;
                res_next.error_code = ERR_READ_RESP;
              end else begin
                phase_next             = PH_TOKEN;
                res_next.tx_valid      = 1'b1;
                res_next.tx_byte       = IDLE_BYTE;
                res_next.select_active = 1'b1;
              end
            end
          end else begin
            poll_counter_next      = poll_counter + 8'd1;
            res_next.tx_valid      = 1'b1;
            res_next.tx_byte       = IDLE_BYTE;
            res_next.select_active = 1'b1;
          end
        end
        PH_OPSEP: begin
          phase_next             = PH_CMD1;
          byte_counter_next      = '0;
          res_next.tx_valid      = 1'b1;
          res_next.tx_byte       = CMD1_CODE;
          res_next.select_active = 1'b1;
        end
        PH_PRE: begin
          res_next.tx_valid = 1'b1;
          if (byte_counter == '0) begin
            byte_counter_next = CNT_W'(1);
            res_next.tx_byte  = IDLE_BYTE;
          end else begin
            phase_next             = PH_CMD17;
            byte_counter_next      = '0;
            res_next.tx_byte       = CMD17_CODE;
            res_next.select_active = 1'b1;
          end
        end
        PH_TOKEN: begin
          if (rx_byte == START_TOKEN) begin
            phase_next             = PH_DATA;
            byte_counter_next      = '0;
            res_next.tx_valid      = 1'b1;
            res_next.tx_byte       = IDLE_BYTE;
            res_next.select_active = 1'b1;
          end else if (rx_byte == IDLE_BYTE) begin
            res_next.tx_valid      = 1'b1;
            res_next.tx_byte       = IDLE_BYTE;
            res_next.select_active = 1'b1;
          end else begin
            phase_next          = PH_IDLE;
            res_next.done_res   = 1'b1;
            res_next.error_code = ERR_TOKEN;
          end
        end
        PH_DATA: begin
          if (inwin) begin
            res_next.data_valid = 1'b1;
            res_next.data_byte  = rx_byte;
            res_next.data_index = IDX_W'(byte_counter - win_lo);
          end
          // block bytes then two CRC bytes
          if (byte_counter >= LAST_POS) begin
            phase_next        = PH_IDLE;
            res_next.done_res = 1'b1;
          end else begin
            byte_counter_next      = byte_counter + CNT_W'(1);
            res_next.tx_valid      = 1'b1;
            res_next.tx_byte       = IDLE_BYTE;
            res_next.select_active = 1'b1;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end else begin
      // stray byte: all-zero response, no state change
      res_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      byte_counter  <= '0;
      poll_counter  <= '0;
      retry_counter <= '0;
      block_address <= '0;
      window_offset <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (accept) begin
        phase         <= phase_next;
        byte_counter  <= byte_counter_next;
        poll_counter  <= poll_counter_next;
        retry_counter <= retry_counter_next;
        block_address <= block_address_next;
        window_offset <= window_offset_next;
      end
      if (in_ready) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign tx_valid      = res.tx_valid;
  assign tx_byte       = res.tx_byte;
  assign select_active = res.select_active;
  assign data_valid    = res.data_valid;
  assign data_byte     = res.data_byte;
  assign data_index    = res.data_index;
  assign done_res      = res.done_res;
  assign error_code    = res.error_code;

endmodule

`default_nettype wire

FILE: test/testbench.sv
module testbench;
  import mmcsbr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_STRAY = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int ITEMS_PER_PHASE = 350;

  typedef enum logic [3:0] {
    S_IDLE, S_DUMMY, S_CMD0, S_RESP0, S_OPSEP, S_CMD1, S_RESP1,
    S_PRE, S_CMD17, S_RESP17, S_TOKEN, S_DATA
  } host_phase_e;

  typedef struct packed {
    host_phase_e ph;
    logic [9:0]  cnt;
    logic [7:0]  polls;
    logic [7:0]  retries;
    logic [31:0] blk;
    logic [8:0]  off;
  } host_state_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] addr;
    logic [7:0]  rx;
  } spi_req_t;

  typedef struct packed {
    logic       txv;
    logic [7:0] tx;
    logic       sel;
    logic       dv;
    logic [7:0] db;
    logic [4:0] di;
    logic       done;
    logic [2:0] err;
  } spi_resp_t;

  typedef struct packed {
    logic [7:0] dummy;
    logic [7:0] retries;
    logic [7:0] polls;
  } host_cfg_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  opcode = '0;
  logic [31:0] address = '0;
  logic [7:0]  rx_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic        select_active;
  logic        data_valid;
  logic [7:0]  data_byte;
  logic [4:0]  data_index;
  logic        done_res;
  logic [2:0]  error_code;

  mmc_spi_block_reader u_top (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .opcode, .address, .rx_byte,
    .out_valid, .out_ready, .tx_valid, .tx_byte, .select_active,
    .data_valid, .data_byte, .data_index, .done_res, .error_code
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  host_cfg_t   cfg = '{dummy: DUMMY_BYTES_RST, retries: OP_RETRIES_RST, polls: RESP_POLLS_RST};
  host_state_t host_st = '0;   // tracks accepted requests
  host_state_t plan_st = '0;   // tracks requests as they are queued
  spi_req_t    cur_req = '0;
  spi_req_t    pending_reqs[$];
  spi_resp_t   expected_resps[$];
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          n_req = 0;
  int          n_resp = 0;
  int          n_bad = 0;
  int          n_win_bytes = 0;
  int          n_windows = 0;
  int          n_status[8];
  int          quiet_cycles = 0;

  function automatic spi_resp_t xfer(logic [7:0] b, logic sel);
    spi_resp_t o;
    o = '0;
    o.txv = 1'b1;
    o.tx = b;
    o.sel = sel;
    return o;
  endfunction

  function automatic spi_resp_t ended(logic [2:0] e);
    spi_resp_t o;
    o = '0;
    o.done = 1'b1;
    o.err = e;
    return o;
  endfunction

  function automatic logic [7:0] frame_byte(host_phase_e ph, int k, logic [31:0] blk);
    if (k == 5) return CMD_CRC;
    if (ph == S_CMD17) return (k == 0) ? CMD17_CODE : 8'(blk >> (8 * (4 - k)));
    if (k == 0) return (ph == S_CMD0) ? CMD0_CODE : CMD1_CODE;
    return 8'h00;
  endfunction

  // Next host state and the response for one request.
  function automatic spi_resp_t step_host(input host_state_t s_in, input spi_req_t q,
                                          input host_cfg_t c, output host_state_t s_out);
    host_state_t s;
    spi_resp_t   o;
    int          limit;
    int          p;
    logic [8:0]  off;
    s = s_in;
    o = '0;
    limit = (c.polls == 0) ? 1 : int'(c.polls);
    p = int'(s.cnt);
    if (q.op == OP_INIT) begin
      s.retries = '0;
      s.polls = '0;
      if (c.dummy == 0) begin
        s.ph = S_CMD0;
        s.cnt = '0;
        o = xfer(CMD0_CODE, 1'b1);
      end else begin
        s.ph = S_DUMMY;
        s.cnt = 10'd1;
        o = xfer(IDLE_BYTE, 1'b0);
      end
    end else if (q.op == OP_READ) begin
      off = 9'(q.addr & (BLOCK_BYTES_DEF - 1));
      if (int'(off) + WINDOW_BYTES_DEF > BLOCK_BYTES_DEF) begin
        s.ph = S_IDLE;
        o = ended(ERR_OFFSET);
      end else begin
        s.off = off;
        s.blk = q.addr & ~(BLOCK_BYTES_DEF - 1);
        s.polls = '0;
        s.ph = S_PRE;
        s.cnt = '0;
        o = xfer(IDLE_BYTE, 1'b0);
      end
    end else if (q.op == OP_RX && s.ph != S_IDLE) begin
      case (s.ph)
        S_DUMMY: begin
          if (s.cnt < c.dummy) begin
            s.cnt = s.cnt + 10'd1;
            o = xfer(IDLE_BYTE, 1'b0);
          end else begin
            s.ph = S_CMD0;
            s.cnt = '0;
            o = xfer(CMD0_CODE, 1'b1);
          end
        end
        S_CMD0, S_CMD1, S_CMD17: begin
          if (s.cnt < 5) begin
            s.cnt = s.cnt + 10'd1;
            o = xfer(frame_byte(s.ph, int'(s.cnt), s.blk), 1'b1);
          end else begin
            s.ph = (s.ph == S_CMD0) ? S_RESP0 : (s.ph == S_CMD1) ? S_RESP1 : S_RESP17;
            s.polls = 8'd1;
            o = xfer(IDLE_BYTE, 1'b1);
          end
        end
        S_RESP0, S_RESP1, S_RESP17: begin
          if (q.rx != IDLE_BYTE || int'(s.polls) >= limit) begin
            // first non-FF byte, or the last poll, is taken as R1
            case (s.ph)
              S_RESP0: begin
                s.retries = '0;
                if (q.rx != R1_IDLE) begin
                  s.ph = S_IDLE;
                  o = ended(ERR_IDLE_RESP);
                end else if (c.retries == 0) begin
                  s.ph = S_IDLE;
                  o = ended(ERR_INIT_TMO);
                end else begin
                  s.ph = S_OPSEP;
                  o = xfer(IDLE_BYTE, 1'b0);
                end
              end
              S_RESP1: begin
                if (q.rx == 8'h00) begin
                  s.ph = S_IDLE;
                  o = ended(ERR_NONE);
                end else begin
                  s.retries = s.retries + 8'd1;
                  if (s.retries >= c.retries) begin
                    s.ph = S_IDLE;
                    o = ended(ERR_INIT_TMO);
                  end else begin
                    s.ph = S_OPSEP;
                    o = xfer(IDLE_BYTE, 1'b0);
                  end
                end
              end
              default: begin
                if (q.rx != 8'h00) begin
                  s.ph = S_IDLE;
                  o = ended(ERR_READ_RESP);
                end else begin
                  s.ph = S_TOKEN;
                  o = xfer(IDLE_BYTE, 1'b1);
                end
              end
            endcase
          end else begin
            s.polls = s.polls + 8'd1;
            o = xfer(IDLE_BYTE, 1'b1);
          end
        end
        S_OPSEP: begin
          s.ph = S_CMD1;
          s.cnt = '0;
          o = xfer(CMD1_CODE, 1'b1);
        end
        S_PRE: begin
          if (s.cnt == 0) begin
            s.cnt = 10'd1;
            o = xfer(IDLE_BYTE, 1'b0);
          end else begin
            s.ph = S_CMD17;
            s.cnt = '0;
            o = xfer(CMD17_CODE, 1'b1);
          end
        end
        S_TOKEN: begin
          if (q.rx == START_TOKEN) begin
            s.ph = S_DATA;
            s.cnt = '0;
            o = xfer(IDLE_BYTE, 1'b1);
          end else if (q.rx == IDLE_BYTE) begin
            o = xfer(IDLE_BYTE, 1'b1);
          end else begin
            s.ph = S_IDLE;
            o = ended(ERR_TOKEN);
          end
        end
        default: begin
          if (p >= s.off && p < int'(s.off) + WINDOW_BYTES_DEF) begin
            o.dv = 1'b1;
            o.db = q.rx;
            o.di = 5'(p - int'(s.off));
          end
          // block bytes plus two CRC bytes
          if (p + 1 >= BLOCK_BYTES_DEF + 2) begin
            s.ph = S_IDLE;
            o.done = 1'b1;
          end else begin
            s.cnt = 10'(p + 1);
            o.txv = 1'b1;
            o.tx = IDLE_BYTE;
            o.sel = 1'b1;
          end
        end
      endcase
    end
    s_out = s;
    return o;
  endfunction

  // What a well-behaved card mostly returns, with some bad bytes mixed in.
  function automatic logic [7:0] card_reply(host_phase_e ph);
    int r;
    r = $urandom_range(99);
    case (ph)
      S_RESP0:  return (r < 55) ? IDLE_BYTE : (r < 93) ? R1_IDLE : 8'($urandom);
      S_RESP1:  return (r < 50) ? IDLE_BYTE : (r < 70) ? R1_IDLE :
                       (r < 95) ? 8'h00 : 8'($urandom);
      S_RESP17: return (r < 50) ? IDLE_BYTE : (r < 94) ? 8'h00 : 8'($urandom);
      S_TOKEN:  return (r < 55) ? IDLE_BYTE : (r < 97) ? START_TOKEN : 8'($urandom);
      S_DATA:   return 8'($urandom);
      default:  return (r < 70) ? IDLE_BYTE : 8'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] read_address();
    logic [31:0] a;
    int          r;
    a = $urandom;
    r = $urandom_range(99);
    if (r < 10) a[8:0] = 9'd0;
    else if (r < 20) a[8:0] = 9'(BLOCK_BYTES_DEF - WINDOW_BYTES_DEF);
    else if (r < 35) a[8:0] = 9'($urandom_range(BLOCK_BYTES_DEF - 1,
                                                BLOCK_BYTES_DEF - WINDOW_BYTES_DEF + 1));
    else a[8:0] = 9'($urandom_range(BLOCK_BYTES_DEF - WINDOW_BYTES_DEF));
    return a;
  endfunction

  task automatic queue_req(logic [1:0] op, logic [31:0] addr, logic [7:0] rx);
    spi_req_t r;
    r = '{op: op, addr: addr, rx: rx};
    pending_reqs.push_back(r);
    void'(step_host(plan_st, r, cfg, plan_st));
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_DUMMY_BYTES: cfg.dummy = val;
      REG_OP_RETRIES:  cfg.retries = val;
      default:         cfg.polls = val;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || in_valid || expected_resps.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_random(int n_items, int idle, int stall);
    int n;
    int r;
    idle_pct = idle;
    stall_pct = stall;
    n = 0;
    while (n < n_items) begin
      r = $urandom_range(999);
      if (plan_st.ph == S_IDLE) begin
        if (r < 400) begin
          queue_req(OP_INIT, $urandom, 8'($urandom));
          n++;
        end else if (r < 850) begin
          queue_req(OP_READ, read_address(), 8'($urandom));
          n++;
        end else begin
          queue_req(r[0] ? OP_RX : OP_STRAY, $urandom, 8'($urandom));
        end
      end else if (r < 4 && n < n_items) begin
        // restart in the middle of an operation
        if (r[0]) queue_req(OP_INIT, $urandom, 8'($urandom));
        else queue_req(OP_READ, read_address(), 8'($urandom));
        n++;
      end else if (r < 14) begin
        queue_req(OP_STRAY, $urandom, 8'($urandom));
      end else begin
        queue_req(OP_RX, $urandom, card_reply(plan_st.ph));
        n++;
      end
    end
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: stray bytes, offset limits, address framing, restarts
    queue_req(OP_RX, 32'h0000_0000, 8'hFF);
    queue_req(OP_STRAY, 32'hFFFF_FFFF, 8'hFF);
    queue_req(OP_READ, 32'h0000_01E1, 8'h00);
    queue_req(OP_READ, 32'hFFFF_FFFF, 8'hFF);
    queue_req(OP_READ, 32'hFFFF_FFE0, 8'h00);
    repeat (7) queue_req(OP_RX, 32'h0, 8'h00);
    queue_req(OP_INIT, 32'hFFFF_FFFF, 8'h00);
    repeat (3) queue_req(OP_RX, 32'hFFFF_FFFF, 8'hFF);
    queue_req(OP_READ, 32'h0000_0000, 8'hFF);
    repeat (3) queue_req(OP_RX, 32'h0, 8'h00);
    queue_req(OP_STRAY, 32'h0, 8'h00);
    run_random(ITEMS_PER_PHASE, 0, 0);

    write_reg(REG_DUMMY_BYTES, 8'd0);
    write_reg(REG_OP_RETRIES, 8'd1);
    write_reg(REG_RESP_POLLS, 8'd1);
    run_random(ITEMS_PER_PHASE, 68, 0);

    write_reg(REG_DUMMY_BYTES, 8'd255);
    write_reg(REG_OP_RETRIES, 8'd0);
    write_reg(REG_RESP_POLLS, 8'd0);
    run_random(ITEMS_PER_PHASE, 0, 68);

    write_reg(REG_DUMMY_BYTES, 8'd2);
    write_reg(REG_OP_RETRIES, 8'd3);
    write_reg(REG_RESP_POLLS, 8'd4);
    run_random(ITEMS_PER_PHASE, 25, 25);

    write_reg(REG_DUMMY_BYTES, 8'd1);
    write_reg(REG_OP_RETRIES, 8'd255);
    write_reg(REG_RESP_POLLS, 8'd255);
    run_random(ITEMS_PER_PHASE, 0, 0);

    $display("%0d requests sent, %0d responses checked, %0d full windows (%0d bytes)",
             n_req, n_resp, n_windows, n_win_bytes);
    $display("completions by status 0..5: %0d %0d %0d %0d %0d %0d",
             n_status[0], n_status[1], n_status[2], n_status[3], n_status[4], n_status[5]);
    if (n_bad == 0) begin
      $display("mmc_spi_block_reader verification clean");
    end else begin
      $display("mmc_spi_block_reader verification failed");
    end
    $finish;
  end

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_resps.push_back(step_host(host_st, cur_req, cfg, host_st));
        n_req++;
      end
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
          cur_req = pending_reqs.pop_front();
          in_valid <= 1'b1;
          opcode <= cur_req.op;
          address <= cur_req.addr;
          rx_byte <= cur_req.rx;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // response monitor
  always @(posedge clk) begin
    spi_resp_t got;
    spi_resp_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{txv: tx_valid, tx: tx_byte, sel: select_active, dv: data_valid,
              db: data_byte, di: data_index, done: done_res, err: error_code};
      n_resp++;
      if (expected_resps.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("unexpected response: txv=%0d tx=%02h sel=%0d done=%0d err=%0d",
                   got.txv, got.tx, got.sel, got.done, got.err);
      end else begin
        want = expected_resps.pop_front();
        if (got !== want) begin
          n_bad++;
          if (n_bad <= 10)
            $display({"response %0d mismatch: exp txv=%0d tx=%02h sel=%0d dv=%0d db=%02h ",
                      "di=%0d done=%0d err=%0d / got txv=%0d tx=%02h sel=%0d dv=%0d ",
                      "db=%02h di=%0d done=%0d err=%0d"}, n_resp,
                     want.txv, want.tx, want.sel, want.dv, want.db, want.di, want.done,
                     want.err, got.txv, got.tx, got.sel, got.dv, got.db, got.di,
                     got.done, got.err);
        end
        if (want.dv) n_win_bytes++;
        if (want.dv && want.di == 5'(WINDOW_BYTES_DEF - 1)) n_windows++;
        if (want.done) n_status[want.err]++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("no handshake for %0d cycles, %0d responses outstanding",
               quiet_cycles, expected_resps.size());
      $display("mmc_spi_block_reader verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

FILE: filelist.f
rtl/mmcsbr_pkg.sv
rtl/mmc_spi_block_reader.sv
test/testbench.sv
